FILE: hdl/ssrq_pkg.sv
package ssrq_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int CNT_OUT_W      = 24;
  localparam logic [23:0] SCALE_ONE = 24'd65536;

  // register indexes on the configuration channel
  localparam logic [7:0] IDX_WIDTH_SCALE = 8'd0;
  localparam logic [7:0] IDX_CROSSED     = 8'd1;

  // datapath commands
  localparam logic [4:0] OP_NOP       = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_DROP      = 5'd2;
  localparam logic [4:0] OP_SCALE     = 5'd3;
  localparam logic [4:0] OP_NORM      = 5'd4;
  localparam logic [4:0] OP_SQ        = 5'd5;
  localparam logic [4:0] OP_SQRT_INIT = 5'd6;
  localparam logic [4:0] OP_SQRT_STEP = 5'd7;
  localparam logic [4:0] OP_DIV_INIT  = 5'd8;
  localparam logic [4:0] OP_DIV_STEP  = 5'd9;
  localparam logic [4:0] OP_DIV_ST    = 5'd10;
  localparam logic [4:0] OP_CROSS     = 5'd11;
  localparam logic [4:0] OP_VM1       = 5'd12;
  localparam logic [4:0] OP_VM2       = 5'd13;
  localparam logic [4:0] OP_VST       = 5'd14;
  localparam logic [4:0] OP_VX_MUL    = 5'd15;
  localparam logic [4:0] OP_VX_ADD    = 5'd16;
  localparam logic [4:0] OP_EMIT_VTX  = 5'd17;
  localparam logic [4:0] OP_BOUNDS    = 5'd18;
  localparam logic [4:0] OP_EMIT_SUM  = 5'd19;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] idx;
    logic       pass;
    logic       ribbon;
    logic [1:0] corner;
    logic       run_end;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic last;
    logic norm_ok;
    logic crossed;
    logic out_free;
  } sts_t;

  // round(x / 2^30), ties away from zero
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] x);
    logic [65:0] mg;
    logic [65:0] q;
    mg = x[65] ? 66'(-x) : 66'(x);
    q  = (mg + 66'd536870912) >> 30;
    rnd30 = x[65] ? -$signed(q[35:0]) : $signed(q[35:0]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    if (x > 36'sd2147483647)       sat32 = 32'sh7FFFFFFF;
    else if (x < -36'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = x[31:0];
  endfunction

endpackage

FILE: hdl/ssrq_ctrl.sv
module ssrq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ssrq_pkg::sts_t   sts,
  output ssrq_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SCALE = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_SQRTI = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_DIVI  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DIVST = 4'd9;
  localparam logic [3:0] S_CROSS = 4'd10;
  localparam logic [3:0] S_VM    = 4'd11;
  localparam logic [3:0] S_VX    = 4'd12;
  localparam logic [3:0] S_VEMIT = 4'd13;
  localparam logic [3:0] S_BOUND = 4'd14;
  localparam logic [3:0] S_SUM   = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       pass_r, pass_nxt;
  logic       ribbon_r, ribbon_nxt;
  logic [1:0] corner_r, corner_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    pass_nxt   = pass_r;
    ribbon_nxt = ribbon_r;
    corner_nxt = corner_r;
    in_tready  = 1'b0;
    cmd.op      = ssrq_pkg::OP_NOP;
    cmd.idx     = idx_r;
    cmd.pass    = pass_r;
    cmd.ribbon  = ribbon_r;
    cmd.corner  = corner_r;
    cmd.run_end = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = ssrq_pkg::OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        idx_nxt = 2'd0;
        if (sts.drop) begin
          cmd.op    = ssrq_pkg::OP_DROP;
          state_nxt = sts.last ? S_SUM : S_IDLE;
        end else begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.op = ssrq_pkg::OP_SCALE;
        if (idx_r == 2'd1) begin
          idx_nxt   = 2'd0;
          state_nxt = S_NORM;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_NORM: begin
        if (sts.norm_ok) begin
          pass_nxt  = 1'b0;
          idx_nxt   = 2'd0;
          state_nxt = S_SQ;
        end else begin
          cmd.op = ssrq_pkg::OP_NORM;
        end
      end
      S_SQ: begin
        cmd.op = ssrq_pkg::OP_SQ;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = S_SQRTI;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_SQRTI: begin
        cmd.op    = ssrq_pkg::OP_SQRT_INIT;
        cnt_nxt   = 5'd0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = ssrq_pkg::OP_SQRT_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.op    = ssrq_pkg::OP_DIV_INIT;
        cnt_nxt   = 5'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = ssrq_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_DIVST;
      end
      S_DIVST: begin
        cmd.op = ssrq_pkg::OP_DIV_ST;
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          cnt_nxt   = 5'd0;
          state_nxt = pass_r ? S_VM : S_CROSS;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_DIVI;
        end
      end
      S_CROSS: begin
        cmd.op    = ssrq_pkg::OP_CROSS;
        pass_nxt  = 1'b1;
        state_nxt = S_SQ;
      end
      S_VM: begin
        case (cnt_r[1:0])
          2'd0:    cmd.op = ssrq_pkg::OP_VM1;
          2'd1:    cmd.op = ssrq_pkg::OP_VM2;
          default: cmd.op = ssrq_pkg::OP_VST;
        endcase
        if (cnt_r[1:0] == 2'd2) begin
          cnt_nxt = 5'd0;
          if (idx_r == 2'd2) begin
            idx_nxt    = 2'd0;
            ribbon_nxt = 1'b0;
            corner_nxt = 2'd0;
            state_nxt  = S_VX;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_VX: begin
        cmd.op  = cnt_r[0] ? ssrq_pkg::OP_VX_ADD : ssrq_pkg::OP_VX_MUL;
        cnt_nxt = {4'd0, ~cnt_r[0]};
        if (cnt_r[0]) begin
          if (idx_r == 2'd2) begin
            idx_nxt   = 2'd0;
            state_nxt = S_VEMIT;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      S_VEMIT: begin
        if (sts.out_free) begin
          cmd.op      = ssrq_pkg::OP_EMIT_VTX;
          cmd.run_end = (corner_r == 2'd3) && (ribbon_r || !sts.crossed) && !sts.last;
          cnt_nxt     = 5'd0;
          if (corner_r == 2'd3) begin
            corner_nxt = 2'd0;
            if (!ribbon_r && sts.crossed) begin
              ribbon_nxt = 1'b1;
              state_nxt  = S_VX;
            end else begin
              state_nxt = S_BOUND;
            end
          end else begin
            corner_nxt = corner_r + 2'd1;
            state_nxt  = S_VX;
          end
        end
      end
      S_BOUND: begin
        cmd.op    = ssrq_pkg::OP_BOUNDS;
        state_nxt = sts.last ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.op      = ssrq_pkg::OP_EMIT_SUM;
          cmd.run_end = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= 5'd0;
      idx_r    <= 2'd0;
      pass_r   <= 1'b0;
      ribbon_r <= 1'b0;
      corner_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      pass_r   <= pass_nxt;
      ribbon_r <= ribbon_nxt;
      corner_r <= corner_nxt;
    end
  end

endmodule

FILE: hdl/ssrq_dp.sv
module ssrq_dp #(
  parameter int COUNT_BITS = ssrq_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ssrq_pkg::cmd_t   cmd,
  output ssrq_pkg::sts_t   sts,
  input  logic [255:0]     in_tdata,
  input  logic             in_tlast,
  input  logic             cfg_valid,
  input  logic [7:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [247:0]     out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);

  // config
  logic [23:0] scale_r;
  logic        crossed_r;

  // segment
  logic signed [31:0] p0_r [3];
  logic signed [31:0] p1_r [3];
  logic        [32:0] m_r  [3];
  logic        [2:0]  dneg_r;
  logic               drop_r, last_r;
  logic        [30:0] rr_r [2];
  logic        [31:0] r0_r, r1_r;

  // shared square-root and divide
  logic [63:0] acc_r, x_r, root_r, bit_r;
  logic [32:0] dv_rem_r;
  logic [31:0] dv_q_r;
  logic        dv_neg_r;

  // frame vectors, Q2.30
  logic signed [31:0] t_r [3];
  logic signed [31:0] c_r [3];
  logic signed [31:0] u_r [3];
  logic signed [31:0] v_r [3];
  logic signed [65:0] vacc_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] pos_r [3];

  // mesh state
  logic [COUNT_BITS-1:0] vcnt_r, kept_r, drp_r;
  logic signed [31:0] blo_r [3];
  logic signed [31:0] bhi_r [3];

  // output register
  logic               ovalid_r, okind_r, otu_r, otv_r, olast_r;
  logic signed [31:0] oa_r [3];
  logic signed [31:0] ob_r [3];
  logic [23:0]        oca_r, ocb_r;

  // comb helpers
  logic signed [31:0] in_p0 [3];
  logic signed [31:0] in_p1 [3];
  logic signed [32:0] in_d  [3];
  logic [31:0]        in_r0, in_r1;
  logic [23:0]        scale_eff;
  logic [31:0]        rsel;
  logic [55:0]        sprod;
  logic [39:0]        sround;
  logic [32:0]        mx;
  logic [31:0]        cmag  [3];
  logic [31:0]        tmag  [3];
  logic [31:0]        sqop;
  logic [63:0]        sqp;
  logic [63:0]        sq_try;
  logic [31:0]        dv_mag;
  logic [63:0]        dv_num;
  logic [32:0]        dv_shift;
  logic               dv_ge;
  logic [31:0]        dv_res;
  logic [1:0]         vm_a, vm_b;
  logic signed [35:0] vst_w;
  logic signed [31:0] across;
  logic [30:0]        rsc;
  logic signed [35:0] vx_off, vx_base, vx_sum;
  logic               plus;
  logic [30:0]        rad;
  logic signed [35:0] lo36 [3];
  logic signed [35:0] hi36 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_p0[i] = in_tdata[32*i +: 32];
      in_p1[i] = in_tdata[128 + 32*i +: 32];
      in_d[i]  = $signed({in_p1[i][31], in_p1[i]}) - $signed({in_p0[i][31], in_p0[i]});
      cmag[i]  = c_r[i][31] ? 32'(-c_r[i]) : 32'(c_r[i]);
      tmag[i]  = t_r[i][31] ? 32'(-t_r[i]) : 32'(t_r[i]);
    end
    in_r0 = in_tdata[96 +: 32];
    in_r1 = in_tdata[224 +: 32];

    scale_eff = (scale_r == 24'd0) ? ssrq_pkg::SCALE_ONE : scale_r;
    rsel      = cmd.idx[0] ? r1_r : r0_r;
    sprod     = 56'(rsel) * 56'(scale_eff);
    sround    = 40'((sprod + 56'h8000) >> 16);

    mx = m_r[0];
    if (m_r[1] > mx) mx = m_r[1];
    if (m_r[2] > mx) mx = m_r[2];

    sqop   = cmd.pass ? cmag[cmd.idx] : m_r[cmd.idx][31:0];
    sqp    = 64'(sqop) * 64'(sqop);
    sq_try = root_r + bit_r;

    dv_mag   = cmd.pass ? cmag[cmd.idx] : m_r[cmd.idx][31:0];
    dv_num   = {2'b00, dv_mag, 30'd0} + {33'd0, root_r[31:1]};
    dv_shift = {dv_rem_r[31:0], dv_q_r[31]};
    dv_ge    = dv_shift >= {1'b0, root_r[31:0]};
    dv_res   = dv_neg_r ? 32'(-dv_q_r) : dv_q_r;

    case (cmd.idx)
      2'd0:    begin vm_a = 2'd1; vm_b = 2'd2; end
      2'd1:    begin vm_a = 2'd2; vm_b = 2'd0; end
      default: begin vm_a = 2'd0; vm_b = 2'd1; end
    endcase
    vst_w = ssrq_pkg::rnd30(vacc_r);

    across  = cmd.ribbon ? v_r[cmd.idx] : u_r[cmd.idx];
    rsc     = cmd.corner[1] ? rr_r[1] : rr_r[0];
    plus    = (cmd.corner == 2'd1) || (cmd.corner == 2'd2);
    vx_off  = ssrq_pkg::rnd30(66'(prod_r));
    vx_base = cmd.corner[1] ? 36'(p1_r[cmd.idx]) : 36'(p0_r[cmd.idx]);
    vx_sum  = plus ? (vx_base + vx_off) : (vx_base - vx_off);

    rad = (rr_r[0] > rr_r[1]) ? rr_r[0] : rr_r[1];
    for (int i = 0; i < 3; i++) begin
      lo36[i] = ((p0_r[i] < p1_r[i]) ? 36'(p0_r[i]) : 36'(p1_r[i])) - $signed({5'd0, rad});
      hi36[i] = ((p0_r[i] > p1_r[i]) ? 36'(p0_r[i]) : 36'(p1_r[i])) + $signed({5'd0, rad});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= ssrq_pkg::SCALE_ONE;
      crossed_r <= 1'b0;
      ovalid_r  <= 1'b0;
      vcnt_r    <= '0;
      kept_r    <= '0;
      drp_r     <= '0;
      for (int i = 0; i < 3; i++) begin
        blo_r[i] <= 32'sh7FFFFFFF;
        bhi_r[i] <= 32'sh80000000;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == ssrq_pkg::IDX_WIDTH_SCALE) scale_r   <= cfg_data[23:0];
        if (cfg_index == ssrq_pkg::IDX_CROSSED)     crossed_r <= cfg_data[0];
      end
      ovalid_r <= (cmd.op == ssrq_pkg::OP_EMIT_VTX) || (cmd.op == ssrq_pkg::OP_EMIT_SUM) ||
                  (ovalid_r && !out_tready);
      case (cmd.op)
        ssrq_pkg::OP_DROP: drp_r <= drp_r + 1'b1;
        ssrq_pkg::OP_EMIT_VTX: vcnt_r <= vcnt_r + 1'b1;
        ssrq_pkg::OP_BOUNDS: begin
          kept_r <= kept_r + 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (ssrq_pkg::sat32(lo36[i]) < blo_r[i]) blo_r[i] <= ssrq_pkg::sat32(lo36[i]);
            if (ssrq_pkg::sat32(hi36[i]) > bhi_r[i]) bhi_r[i] <= ssrq_pkg::sat32(hi36[i]);
          end
        end
        ssrq_pkg::OP_EMIT_SUM: begin
          vcnt_r   <= '0;
          kept_r   <= '0;
          drp_r    <= '0;
          for (int i = 0; i < 3; i++) begin
            blo_r[i] <= 32'sh7FFFFFFF;
            bhi_r[i] <= 32'sh80000000;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ssrq_pkg::OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          p0_r[i]   <= in_p0[i];
          p1_r[i]   <= in_p1[i];
          dneg_r[i] <= in_d[i][32];
          m_r[i]    <= in_d[i][32] ? 33'(-in_d[i]) : 33'(in_d[i]);
        end
        r0_r   <= in_r0;
        r1_r   <= in_r1;
        last_r <= in_tlast;
        drop_r <= in_r0[31] | in_r1[31] |
                  ((in_p0[0] == in_p1[0]) && (in_p0[1] == in_p1[1]) && (in_p0[2] == in_p1[2]));
      end
      ssrq_pkg::OP_SCALE: begin
        rr_r[cmd.idx[0]] <= (sround > 40'h7FFFFFFF) ? 31'h7FFFFFFF : sround[30:0];
      end
      ssrq_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++)
          m_r[i] <= (mx[32:30] != 3'd0) ? (m_r[i] >> 1) : (m_r[i] << 1);
      end
      ssrq_pkg::OP_SQ: acc_r <= (cmd.idx == 2'd0) ? sqp : (acc_r + sqp);
      ssrq_pkg::OP_SQRT_INIT: begin
        x_r    <= acc_r;
        root_r <= 64'd0;
        bit_r  <= 64'h4000_0000_0000_0000;
      end
      ssrq_pkg::OP_SQRT_STEP: begin
        if (x_r >= sq_try) begin
          x_r    <= x_r - sq_try;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ssrq_pkg::OP_DIV_INIT: begin
        dv_rem_r <= {1'b0, dv_num[63:32]};
        dv_q_r   <= dv_num[31:0];
        dv_neg_r <= cmd.pass ? c_r[cmd.idx][31] : dneg_r[cmd.idx];
      end
      ssrq_pkg::OP_DIV_STEP: begin
        dv_rem_r <= dv_ge ? (dv_shift - {1'b0, root_r[31:0]}) : dv_shift;
        dv_q_r   <= {dv_q_r[30:0], dv_ge};
      end
      ssrq_pkg::OP_DIV_ST: begin
        if (cmd.pass) u_r[cmd.idx] <= (root_r[31:0] == 32'd0) ? 32'sd0 : $signed(dv_res);
        else          t_r[cmd.idx] <= (root_r[31:0] == 32'd0) ? 32'sd0 : $signed(dv_res);
      end
      ssrq_pkg::OP_CROSS: begin
        if (tmag[0] <= tmag[1] && tmag[0] <= tmag[2]) begin
          c_r[0] <= 32'sd0;  c_r[1] <= t_r[2];   c_r[2] <= -t_r[1];
        end else if (tmag[1] <= tmag[2]) begin
          c_r[0] <= -t_r[2]; c_r[1] <= 32'sd0;   c_r[2] <= t_r[0];
        end else begin
          c_r[0] <= t_r[1];  c_r[1] <= -t_r[0];  c_r[2] <= 32'sd0;
        end
      end
      ssrq_pkg::OP_VM1: vacc_r <= t_r[vm_a] * u_r[vm_b];
      ssrq_pkg::OP_VM2: vacc_r <= vacc_r - t_r[vm_b] * u_r[vm_a];
      ssrq_pkg::OP_VST: v_r[cmd.idx] <= vst_w[31:0];
      ssrq_pkg::OP_VX_MUL: prod_r <= across * $signed({1'b0, rsc});
      ssrq_pkg::OP_VX_ADD: pos_r[cmd.idx] <= ssrq_pkg::sat32(vx_sum);
      ssrq_pkg::OP_EMIT_VTX: begin
        okind_r <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          oa_r[i] <= pos_r[i];
          ob_r[i] <= cmd.ribbon ? u_r[i] : v_r[i];
        end
        otu_r   <= plus;
        otv_r   <= cmd.corner[1];
        oca_r   <= 24'(vcnt_r);
        ocb_r   <= 24'd0;
        olast_r <= cmd.run_end;
      end
      ssrq_pkg::OP_EMIT_SUM: begin
        okind_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          oa_r[i] <= (kept_r == '0) ? 32'sd0 : blo_r[i];
          ob_r[i] <= (kept_r == '0) ? 32'sd0 : bhi_r[i];
        end
        otu_r   <= 1'b0;
        otv_r   <= 1'b0;
        oca_r   <= 24'(kept_r);
        ocb_r   <= 24'(drp_r);
        olast_r <= cmd.run_end;
      end
      default: ;
    endcase
  end

  assign sts.drop     = drop_r;
  assign sts.last     = last_r;
  assign sts.norm_ok  = (mx[32:30] == 3'd0) && mx[29];
  assign sts.crossed  = crossed_r;
  assign sts.out_free = !ovalid_r || out_tready;

  assign out_tvalid = ovalid_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {6'd0, ocb_r, oca_r, otv_r, otu_r,
                       ob_r[2], ob_r[1], ob_r[0], oa_r[2], oa_r[1], oa_r[0]};

endmodule

FILE: hdl/strand_segment_to_ribbon_quads.sv
// Channel | Dir | Handshake                  | Payload
// in_     | in  | in_tvalid / in_tready      | tdata: segment endpoints and radii, tlast: last
// out_    | out | out_tvalid / out_tready    | tdata: position/low bound, normal/high bound, uv, counts,
//         |     |                            | tuser: kind, tlast: run end
// cfg_    | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One segment at a time. A dropped segment is loaded, checked and dropped. A kept one takes
// up to 29 normalising shifts, two 32-step square roots and six 32-step divides on one
// shared unit, then per vertex a multiply and an add on each axis and an emit. After the
// last segment, kept or dropped, a summary is emitted.
// Reset (rst_n low, synchronous) restores scale 1.0, single ribbons and a fresh mesh.
// A result waits in the output register; the sequencer stalls only when it needs
// that register again.
module strand_segment_to_ribbon_quads #(
  parameter int COUNT_BITS = ssrq_pkg::COUNT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // start_x, start_y, start_z, start_radius, end_x, end_y, end_z, end_radius (32 b each)
  input  logic [255:0] in_tdata,
  input  logic         in_tlast,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z (32 b), tex_u, tex_v (1 b), count_a, count_b (24 b), pad
  output logic [247:0] out_tdata,
  // kind
  output logic         out_tuser,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  ssrq_pkg::cmd_t cmd;
  ssrq_pkg::sts_t sts;

  // registers are taken at any time; the user must write only while idle (not enforced here)
  assign cfg_ready = 1'b1;

  ssrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssrq_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
